// ===== rtl/ipsw_pkg.sv =====
package ipsw_pkg;

  // Field widths of one transaction.
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PFX_W    = 6;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;

  // Longest prefix: a single host.
  localparam logic [PFX_W-1:0] FULL_PREFIX = PFX_W'(32);

  // Operation codes carried in tuser.
  localparam logic [OP_W-1:0] OP_LOOKUP   = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOW    = 2'd1;
  localparam logic [OP_W-1:0] OP_DISALLOW = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the incoming transaction
    logic cmp_en;  // register the per-entry hit vector
    logic commit;  // update the table and load the result register
  } ipsw_cmd_t;

  // Prefix lengths above the full width saturate to a single host.
  function automatic logic [PFX_W-1:0] clamp_prefix(input logic [PFX_W-1:0] p);
    clamp_prefix = (p > FULL_PREFIX) ? FULL_PREFIX : p;
  endfunction

  // Network mask for a prefix length; zero gives an empty mask.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PFX_W-1:0] p);
    if (p >= FULL_PREFIX) begin
      prefix_mask = '1;
    end else begin
      prefix_mask = ~({ADDR_W{1'b1}} >> p);
    end
  endfunction

endpackage

// ===== rtl/ipv4_subnet_whitelist_table.sv =====
// A transaction is captured, compared into a hit vector, then resolved into the result register.
// No new transaction is accepted during the compare step; resolve waits for a free result register.
// The next input is taken in the resolve cycle while the result register drains.
// Reset (rst, synchronous, active high) empties the table at once and drops output valid.
// Table payload is not reset; only valid cells are ever matched.
module ipv4_subnet_whitelist_table
  import ipsw_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] ip_address, [37:32] prefix_length, rest zero
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] allowed, [2:1] status, rest zero
);

  ipsw_cmd_t           cmd;
  logic                res_allowed;
  logic [STATUS_W-1:0] res_status;

  // Controller: handshakes and sequencing.
  ipsw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // Datapath: subnet table, parallel compare and result register.
  ipsw_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_opcode   (s_tuser),
    .in_addr     (s_tdata[31:0]),
    .in_prefix   (s_tdata[37:32]),
    .res_allowed (res_allowed),
    .res_status  (res_status)
  );

  assign m_tdata = {5'b0, res_status, res_allowed};

endmodule

// ===== rtl/ipsw_datapath.sv =====
module ipsw_datapath
  import ipsw_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  ipsw_cmd_t           cmd,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [ADDR_W-1:0]   in_addr,
  input  logic [PFX_W-1:0]    in_prefix,
  output logic                res_allowed,
  output logic [STATUS_W-1:0] res_status
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Table cells: valid bits are reset, payload is written on allow.
  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [ADDR_W-1:0]        entry_base   [TABLE_ENTRIES];
  logic [PFX_W-1:0]         entry_prefix [TABLE_ENTRIES];

  // Captured transaction.
  logic [OP_W-1:0]   op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] base_q;
  logic [PFX_W-1:0]  pfx_q;

  logic [TABLE_ENTRIES-1:0] hit_next;
  logic [TABLE_ENTRIES-1:0] hit_q;
  logic                     hit_any;
  logic [IDX_W-1:0]         hit_idx;
  logic [PFX_W-1:0]         in_pfx_clamped;

  // Clamp the prefix and mask the base as the transaction is captured.
  assign in_pfx_clamped = clamp_prefix(in_prefix);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= in_opcode;
      addr_q <= in_addr;
      pfx_q  <= in_pfx_clamped;
      base_q <= in_addr & prefix_mask(in_pfx_clamped);
    end
  end

  // Every cell compares in parallel; what counts as a hit depends on the opcode.
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      case (op_q)
        OP_LOOKUP: begin
          hit_next[i] = entry_valid[i] &&
                        ((addr_q & prefix_mask(entry_prefix[i])) == entry_base[i]);
        end
        OP_ALLOW: begin
          hit_next[i] = !entry_valid[i];
        end
        OP_DISALLOW: begin
          hit_next[i] = entry_valid[i] && (entry_prefix[i] == pfx_q) &&
                        (entry_base[i] == base_q);
        end
        default: begin
          hit_next[i] = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp_en) begin
      hit_q <= hit_next;
    end
  end

  // Lowest hit wins.
  always_comb begin
    hit_any = |hit_q;
    hit_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (hit_q[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  // Valid bits: set on allow, cleared on disallow, all cleared on clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.commit) begin
      case (op_q)
        OP_ALLOW: begin
          if (hit_any) begin
            entry_valid[hit_idx] <= 1'b1;
          end
        end
        OP_DISALLOW: begin
          if (hit_any) begin
            entry_valid[hit_idx] <= 1'b0;
          end
        end
        OP_CLEAR: begin
          entry_valid <= '0;
        end
        default: begin
          entry_valid <= entry_valid;
        end
      endcase
    end
  end

  // Subnet payload written into the lowest free cell.
  always_ff @(posedge clk) begin
    if (cmd.commit && (op_q == OP_ALLOW) && hit_any) begin
      entry_base[hit_idx]   <= base_q;
      entry_prefix[hit_idx] <= pfx_q;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_allowed <= (op_q == OP_LOOKUP) && hit_any;
      if ((op_q == OP_ALLOW) && !hit_any) begin
        res_status <= ST_FULL;
      end else if ((op_q == OP_DISALLOW) && !hit_any) begin
        res_status <= ST_NOMATCH;
      end else begin
        res_status <= ST_OK;
      end
    end
  end

endmodule

// ===== rtl/ipsw_ctrl.sv =====
module ipsw_ctrl
  import ipsw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  output ipsw_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_RES  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;
  logic       accept;
  logic       commit;

  // The result register may be reloaded when empty or being drained.
  assign out_free = !m_tvalid || m_tready;
  assign commit   = (state == S_RES) && out_free;
  assign s_tready = (state == S_IDLE) || commit;
  assign accept   = s_tvalid && s_tready;

  assign cmd.load   = accept;
  assign cmd.cmp_en = (state == S_CMP);
  assign cmd.commit = commit;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_RES;
      end
      S_RES: begin
        if (commit) begin
          state_next = accept ? S_CMP : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid flag for the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // A comparison is always followed by resolution.
  a_cmp_to_res: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |=> (state == S_RES))
    else $error("compare stage not followed by resolution");

  // No new transaction is taken while a comparison is in flight.
  a_no_accept_in_cmp: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> !s_tready)
    else $error("input accepted during compare");

  // A committed result is presented on the next cycle.
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    commit |=> m_tvalid)
    else $error("committed result not presented");

  // An accepted transaction always moves into the compare stage.
  a_accept_to_cmp: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_CMP))
    else $error("accepted transaction did not start a compare");

endmodule

// ===== sim/ipv4_subnet_whitelist_table_tb.sv =====
module ipv4_subnet_whitelist_table_tb
  import ipsw_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES     = 16;
  localparam int unsigned ITEM_TARGET = 1450;

  // One request to the table, or a marker that makes the sender wait for all results.
  typedef struct {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [PFX_W-1:0]  pfx;
    bit                pause;
  } acl_req_t;

  // The answer expected for one request.
  typedef struct packed {
    logic                allowed;
    logic [STATUS_W-1:0] status;
  } acl_verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [31:0] ip_address, [37:32] prefix_length, rest zero
  logic [1:0]  s_tuser = '0;   // [1:0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [0] allowed, [2:1] status, rest zero

  // Shadow copy of the subnet table.
  logic              tbl_valid [ENTRIES];
  logic [ADDR_W-1:0] tbl_base  [ENTRIES];
  logic [PFX_W-1:0]  tbl_pfx   [ENTRIES];

  acl_req_t     request_q [$];
  acl_verdict_t verdict_q [$];
  acl_req_t     live_req;
  int           requests_queued = 0;
  int           requests_sent = 0;
  int           answers_seen = 0;
  int           mismatch_count = 0;
  int           stall_left = 0;
  bit           calm;

  ipv4_subnet_whitelist_table #(
    .TABLE_ENTRIES(ENTRIES)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #10 clk = ~clk;

  // A stretch in the middle of the run with no idling on either side.
  assign calm = (requests_sent >= 500) && (requests_sent < 800);

  // Network mask for an already saturated prefix length.
  function automatic logic [ADDR_W-1:0] net_mask(input logic [PFX_W-1:0] p);
    if (p == 0) begin
      return '0;
    end
    if (p >= FULL_PREFIX) begin
      return '1;
    end
    return 32'hFFFF_FFFF << (32 - p);
  endfunction

  function automatic logic [PFX_W-1:0] sat_prefix(input logic [PFX_W-1:0] p);
    return (p > FULL_PREFIX) ? FULL_PREFIX : p;
  endfunction

  // Updates the shadow table for one accepted transaction and records its answer.
  function automatic void apply_acl_request(input acl_req_t r);
    logic [PFX_W-1:0]  p;
    logic [ADDR_W-1:0] base;
    acl_verdict_t      v;
    bit                done;
    p    = sat_prefix(r.pfx);
    base = r.addr & net_mask(p);
    v.allowed = 1'b0;
    v.status  = ST_OK;
    done = 1'b0;
    case (r.op)
      OP_LOOKUP: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_valid[i] && ((r.addr & net_mask(tbl_pfx[i])) == tbl_base[i])) begin
            v.allowed = 1'b1;
          end
        end
      end
      OP_ALLOW: begin
        v.status = ST_FULL;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!done && !tbl_valid[i]) begin
            tbl_valid[i] = 1'b1;
            tbl_base[i]  = base;
            tbl_pfx[i]   = p;
            v.status = ST_OK;
            done = 1'b1;
          end
        end
      end
      OP_DISALLOW: begin
        v.status = ST_NOMATCH;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!done && tbl_valid[i] && tbl_pfx[i] == p && tbl_base[i] == base) begin
            tbl_valid[i] = 1'b0;
            v.status = ST_OK;
            done = 1'b1;
          end
        end
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++) begin
          tbl_valid[i] = 1'b0;
        end
      end
    endcase
    verdict_q.push_back(v);
  endfunction

  task automatic queue_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                               input logic [PFX_W-1:0] pfx);
    acl_req_t r;
    r.op = op;
    r.addr = addr;
    r.pfx = pfx;
    r.pause = 1'b0;
    request_q.push_back(r);
    requests_queued++;
  endtask

  // Mostly realistic prefixes, with the empty mask and out-of-range values mixed in.
  function automatic logic [PFX_W-1:0] pick_prefix();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      return '0;
    end
    if (roll < 18) begin
      return PFX_W'($urandom_range(33, 63));
    end
    if (roll < 30) begin
      return FULL_PREFIX;
    end
    return PFX_W'($urandom_range(1, 31));
  endfunction

  // Random address inside a subnet.
  function automatic logic [ADDR_W-1:0] host_in(input logic [ADDR_W-1:0] base,
                                                input logic [PFX_W-1:0] pfx);
    logic [ADDR_W-1:0] m;
    m = net_mask(sat_prefix(pfx));
    return (base & m) | ($urandom & ~m);
  endfunction

  // Reset, held from the start and then released.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // Table is empty after reset.
  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_base[i]  = '0;
      tbl_pfx[i]   = '0;
    end
  end

  // Stimulus: a directed opening, then random request sequences.
  initial begin
    logic [ADDR_W-1:0] pool_addr [$];
    logic [PFX_W-1:0]  pool_pfx  [$];
    logic [ADDR_W-1:0] a;
    logic [PFX_W-1:0]  p;
    acl_req_t          marker;
    int                roll;
    int                k;
    int                idx;
    int                next_pause;

    // Empty table, then an unmasked /24 base with a near miss on the prefix.
    queue_request(OP_LOOKUP,   32'hFFFF_FFFF, 6'd63);
    queue_request(OP_ALLOW,    32'hC0A8_01FF, 6'd24);
    queue_request(OP_LOOKUP,   32'hC0A8_0105, 6'd0);
    queue_request(OP_LOOKUP,   32'hC0A9_0105, 6'd0);
    queue_request(OP_DISALLOW, 32'hC0A8_0100, 6'd25);
    queue_request(OP_DISALLOW, 32'hC0A8_01AB, 6'd24);
    // Oversized prefixes saturate to a single host.
    queue_request(OP_ALLOW,    32'h0A00_0001, 6'd63);
    queue_request(OP_LOOKUP,   32'h0A00_0001, 6'd0);
    queue_request(OP_LOOKUP,   32'h0A00_0000, 6'd0);
    queue_request(OP_DISALLOW, 32'h0A00_0001, 6'd33);
    // A zero prefix matches every address.
    queue_request(OP_ALLOW,    32'h1234_5678, 6'd0);
    queue_request(OP_LOOKUP,   32'h0000_0000, 6'd32);
    queue_request(OP_LOOKUP,   32'hFFFF_FFFF, 6'd32);
    queue_request(OP_CLEAR,    32'hFFFF_FFFF, 6'd63);
    queue_request(OP_LOOKUP,   32'hFFFF_FFFF, 6'd0);
    // A hole left by a disallow is refilled by the next allow.
    queue_request(OP_ALLOW,    32'hAC10_0000, 6'd12);
    queue_request(OP_ALLOW,    32'h0A0B_0C0D, 6'd32);
    queue_request(OP_DISALLOW, 32'hAC1F_FFFF, 6'd12);
    queue_request(OP_ALLOW,    32'h6400_0000, 6'd8);
    queue_request(OP_LOOKUP,   32'hAC10_0001, 6'd0);
    queue_request(OP_LOOKUP,   32'h64FF_0000, 6'd0);
    queue_request(OP_CLEAR,    32'h0000_0000, 6'd0);

    marker.op = OP_LOOKUP;
    marker.addr = '0;
    marker.pfx = '0;
    marker.pause = 1'b1;
    request_q.push_back(marker);
    next_pause = requests_queued + 400;

    while (requests_queued < ITEM_TARGET) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        // Whole-list set, sometimes longer than the table.
        queue_request(OP_CLEAR, $urandom, PFX_W'($urandom_range(0, 63)));
        pool_addr.delete();
        pool_pfx.delete();
        k = $urandom_range(1, ENTRIES + 4);
        for (int i = 0; i < k; i++) begin
          a = $urandom;
          p = pick_prefix();
          queue_request(OP_ALLOW, a, p);
          pool_addr.push_back(a);
          pool_pfx.push_back(p);
        end
      end else if (roll < 38) begin
        a = $urandom;
        p = pick_prefix();
        queue_request(OP_ALLOW, a, p);
        pool_addr.push_back(a);
        pool_pfx.push_back(p);
        if (pool_addr.size() > 32) begin
          pool_addr.delete(0);
          pool_pfx.delete(0);
        end
      end else if (roll < 55) begin
        if (pool_addr.size() != 0 && $urandom_range(0, 3) != 0) begin
          idx = $urandom_range(0, pool_addr.size() - 1);
          p = pool_pfx[idx];
          if (sat_prefix(p) == FULL_PREFIX) begin
            p = PFX_W'($urandom_range(32, 63));
          end
          queue_request(OP_DISALLOW, host_in(pool_addr[idx], p), p);
          pool_addr.delete(idx);
          pool_pfx.delete(idx);
        end else begin
          queue_request(OP_DISALLOW, $urandom, pick_prefix());
        end
      end else if (roll < 90) begin
        if (pool_addr.size() != 0 && $urandom_range(0, 9) < 6) begin
          idx = $urandom_range(0, pool_addr.size() - 1);
          a = host_in(pool_addr[idx], pool_pfx[idx]);
        end else begin
          a = $urandom;
        end
        queue_request(OP_LOOKUP, a, PFX_W'($urandom_range(0, 63)));
      end else if (roll < 92) begin
        queue_request(OP_CLEAR, $urandom, PFX_W'($urandom_range(0, 63)));
        pool_addr.delete();
        pool_pfx.delete();
      end else begin
        queue_request(OP_W'($urandom_range(0, 3)), $urandom, PFX_W'($urandom_range(0, 63)));
      end
      if (requests_queued >= next_pause) begin
        request_q.push_back(marker);
        next_pause = requests_queued + 400;
      end
    end

    // Wait for the last transaction to be accepted and answered.
    @(posedge clk);
    while (request_q.size() != 0 || s_tvalid || verdict_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Sender: offers queued requests, idling at random and pausing on a marker.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_acl_request(live_req);
        requests_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (request_q.size() != 0 && request_q[0].pause) begin
          if (verdict_q.size() == 0) begin
            request_q.delete(0);
          end
          s_tvalid <= 1'b0;
        end else if (request_q.size() != 0 && (calm || $urandom_range(0, 99) >= 6)) begin
          live_req = request_q.pop_front();
          s_tdata  <= {2'b00, live_req.pfx, live_req.addr};
          s_tuser  <= live_req.op;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each answer against the oldest expectation.
  always @(posedge clk) begin
    acl_verdict_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        answers_seen++;
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual allowed %0d status %0d",
                   $time, m_tdata[0], m_tdata[2:1]);
          mismatch_count++;
        end else begin
          want = verdict_q.pop_front();
          if (m_tdata[0] !== want.allowed) begin
            $display("%0t: allowed mismatch, expected %0d, actual %0d",
                     $time, want.allowed, m_tdata[0]);
            mismatch_count++;
          end
          if (m_tdata[2:1] !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, m_tdata[2:1]);
            mismatch_count++;
          end
        end
      end
      // Two long hold-offs let the block back up into its input.
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        m_tready <= 1'b0;
      end else if (m_tvalid && m_tready && (answers_seen == 300 || answers_seen == 1000)) begin
        stall_left <= 80;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  // Watchdog.
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
